/* src/obbsat_pkg.sv */
// Shared constants, pair tables and control types for the oriented box overlap test.
package obbsat_pkg;

    // Default coordinate width (signed Q15.8 at 24 bits).
    localparam int COORD_BITS_DEF = 24;

    // Edge vectors: left a, left b, right a, right b.
    localparam int N_EDGES = 4;

    // Distinct edge dot products (dot is symmetric).
    localparam int N_DOTS = 10;

    // Edge indices feeding each distinct dot product.
    localparam int PAIR_A [N_DOTS] = '{0, 1, 2, 3, 0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [N_DOTS] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

    // Dot product index of edge j projected on axis edge i.
    localparam int DOT_IDX [N_EDGES][N_EDGES] = '{
        '{0, 4, 5, 6},
        '{4, 1, 7, 8},
        '{5, 7, 2, 9},
        '{6, 8, 9, 3}
    };

    // Load enables for the two registered stages of a dot product lane.
    typedef struct packed {
        logic prod;
        logic dot;
    } t_lane_en;

endpackage

/* src/oriented_box_overlap_test_unit.sv */
// Top level of the 2D oriented box overlap test (separating axis, one axis per edge).
// Pipeline registers from input transfer to o_out_valid: input, product, dot magnitude,
//   axis sum, result.
// Throughput: one box pair per cycle while i_out_ready keeps up; every stage advances independently, so
//   bubbles close up while a finished result waits on i_out_ready.
// Reset (synchronous, active low) clears all stage valid bits; data registers keep junk.
module oriented_box_overlap_test_unit #(
    parameter int COORD_BITS = obbsat_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [COORD_BITS-1:0] i_left_edge_a_x,
    input  logic signed [COORD_BITS-1:0] i_left_edge_a_y,
    input  logic signed [COORD_BITS-1:0] i_left_edge_b_x,
    input  logic signed [COORD_BITS-1:0] i_left_edge_b_y,
    input  logic signed [COORD_BITS-1:0] i_left_center_x,
    input  logic signed [COORD_BITS-1:0] i_left_center_y,
    input  logic signed [COORD_BITS-1:0] i_right_edge_a_x,
    input  logic signed [COORD_BITS-1:0] i_right_edge_a_y,
    input  logic signed [COORD_BITS-1:0] i_right_edge_b_x,
    input  logic signed [COORD_BITS-1:0] i_right_edge_b_y,
    input  logic signed [COORD_BITS-1:0] i_right_center_x,
    input  logic signed [COORD_BITS-1:0] i_right_center_y,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_overlap
);

    localparam int NE = obbsat_pkg::N_EDGES;
    localparam int ND = obbsat_pkg::N_DOTS;
    localparam int DB = COORD_BITS + 1;       // center difference width
    localparam int EM = 2 * COORD_BITS;       // edge dot magnitude width
    localparam int CM = 2 * COORD_BITS + 1;   // center dot magnitude width

    // ------------------------------------------------------------------
    // Stage control. Stage k loads when it is empty or its contents move
    // on this cycle; the chain starts at the result register.
    // ------------------------------------------------------------------
    logic [5:1] r_v;
    logic [5:1] en;

    always_comb begin
        en[5] = !r_v[5] || i_out_ready;
        for (int k = 4; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[1]) begin
                r_v[1] <= i_in_valid;
            end
            for (int k = 2; k <= 5; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture edges, form center difference d = right - left.
    // ------------------------------------------------------------------
    logic signed [COORD_BITS-1:0] r_ex [NE];
    logic signed [COORD_BITS-1:0] r_ey [NE];
    logic signed [DB-1:0]         r_dx;
    logic signed [DB-1:0]         r_dy;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ex[0] <= i_left_edge_a_x;
            r_ey[0] <= i_left_edge_a_y;
            r_ex[1] <= i_left_edge_b_x;
            r_ey[1] <= i_left_edge_b_y;
            r_ex[2] <= i_right_edge_a_x;
            r_ey[2] <= i_right_edge_a_y;
            r_ex[3] <= i_right_edge_b_x;
            r_ey[3] <= i_right_edge_b_y;
            r_dx    <= DB'(i_right_center_x) - DB'(i_left_center_x);
            r_dy    <= DB'(i_right_center_y) - DB'(i_left_center_y);
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-3: dot product lanes. Ten lanes cover every edge pair
    // (symmetric), four more project d on each edge axis.
    // ------------------------------------------------------------------
    obbsat_pkg::t_lane_en lane_en;
    assign lane_en.prod = en[2];
    assign lane_en.dot  = en[3];

    logic [EM-1:0] dot_mag [ND];
    logic [CM-1:0] cen_mag [NE];

    for (genvar k = 0; k < ND; k++) begin : g_edge_dot
        obbsat_dot #(
            .A_BITS (COORD_BITS),
            .B_BITS (COORD_BITS)
        ) u_dot (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_a_x (r_ex[obbsat_pkg::PAIR_A[k]]),
            .i_a_y (r_ey[obbsat_pkg::PAIR_A[k]]),
            .i_b_x (r_ex[obbsat_pkg::PAIR_B[k]]),
            .i_b_y (r_ey[obbsat_pkg::PAIR_B[k]]),
            .o_mag (dot_mag[k])
        );
    end

    for (genvar i = 0; i < NE; i++) begin : g_cen_dot
        obbsat_dot #(
            .A_BITS (DB),
            .B_BITS (COORD_BITS)
        ) u_dot (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_a_x (r_dx),
            .i_a_y (r_dy),
            .i_b_x (r_ex[i]),
            .i_b_y (r_ey[i]),
            .o_mag (cen_mag[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: per axis, sum of |e_j . p| against 2|d . p| (unnormalized p).
    // ------------------------------------------------------------------
    logic [NE-1:0] apart;

    for (genvar i = 0; i < NE; i++) begin : g_axis
        logic [EM-1:0] terms [NE];

        for (genvar j = 0; j < NE; j++) begin : g_term
            assign terms[j] = dot_mag[obbsat_pkg::DOT_IDX[i][j]];
        end

        obbsat_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .i_clk   (i_clk),
            .i_en    (en[4]),
            .i_terms (terms),
            .i_cen   (cen_mag[i]),
            .o_apart (apart[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage 5: result register. Overlap unless some axis separates.
    // ------------------------------------------------------------------
    logic r_overlap;

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_overlap <= ~(|apart);
        end
    end

    assign o_out_valid = r_v[5];
    assign o_overlap   = r_overlap;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // An empty result register frees the whole pipe for a new transfer.
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // A result taken this cycle never blocks the input side.
    a_ready_on_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("input stalled while result drains");

    // An accepted transfer occupies the first stage on the next cycle.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_v[1])
        else $error("accepted transfer lost at stage 1");

    // A stalled stage 4 keeps its item.
    a_stage4_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[4] && !en[5]) |=> r_v[4])
        else $error("stalled item dropped at stage 4");

endmodule

/* src/obbsat_dot.sv */
// Dot product lane: registered products, then registered magnitude of their sum.
module obbsat_dot #(
    parameter int A_BITS = obbsat_pkg::COORD_BITS_DEF,
    parameter int B_BITS = obbsat_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  obbsat_pkg::t_lane_en       i_en,
    input  logic signed [A_BITS-1:0]   i_a_x,
    input  logic signed [A_BITS-1:0]   i_a_y,
    input  logic signed [B_BITS-1:0]   i_b_x,
    input  logic signed [B_BITS-1:0]   i_b_y,
    output logic [A_BITS+B_BITS-1:0]   o_mag
);

    localparam int PW = A_BITS + B_BITS;
    localparam int SW = PW + 1;

    logic signed [PW-1:0] r_px;
    logic signed [PW-1:0] r_py;
    logic signed [PW-1:0] n_px;
    logic signed [PW-1:0] n_py;
    logic signed [SW-1:0] n_sum;
    logic [PW-1:0]        n_mag;
    logic [PW-1:0]        r_mag;

    assign n_px  = PW'(i_a_x) * PW'(i_b_x);
    assign n_py  = PW'(i_a_y) * PW'(i_b_y);
    assign n_sum = SW'(r_px) + SW'(r_py);

    // |sum| fits in PW bits unsigned
    always_comb begin
        if (n_sum[SW-1]) begin
            n_mag = PW'(-n_sum);
        end else begin
            n_mag = PW'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        if (i_en.dot) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag = r_mag;

endmodule

/* src/obbsat_axis.sv */
// One trial axis: registered sum of projected extents and doubled center distance.
module obbsat_axis #(
    parameter int COORD_BITS = obbsat_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [2*COORD_BITS-1:0] i_terms [obbsat_pkg::N_EDGES],
    input  logic [2*COORD_BITS:0]   i_cen,
    output logic                    o_apart
);

    localparam int SW = 2 * COORD_BITS + 2;

    logic [SW-1:0] r_sum;
    logic [SW-1:0] r_cen2;
    logic [SW-1:0] n_sum;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < obbsat_pkg::N_EDGES; j++) begin
            n_sum = n_sum + SW'(i_terms[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_cen2 <= {i_cen, 1'b0};
        end
    end

    // strict: touching does not separate
    assign o_apart = (r_sum < r_cen2);

endmodule
